// ===== design/mfhp_pkg.sv =====
// ============================================================================
// Media frame header parser package
// Types, fail codes, register indexes and header layout constants shared by
// the parser modules and the port checker.
// ============================================================================
package mfhp_pkg;

  // Fixed header layout.
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned COUNT_W      = 33;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Byte offsets inside the header where each section begins.
  localparam logic [4:0] OFS_VERSION = 5'd4;
  localparam logic [4:0] OFS_KIND    = 5'd5;
  localparam logic [4:0] OFS_STREAM  = 5'd8;
  localparam logic [4:0] OFS_SEQ     = 5'd12;
  localparam logic [4:0] OFS_TIME    = 5'd16;
  localparam logic [4:0] OFS_LENGTH  = 5'd20;

  // Configuration register indexes.
  localparam logic [2:0] REG_VERSION     = 3'd0;
  localparam logic [2:0] REG_MAX_PAYLOAD = 3'd1;
  localparam logic [2:0] REG_KIND_A      = 3'd2;
  localparam logic [2:0] REG_KIND_B      = 3'd3;
  localparam logic [2:0] REG_KIND_C      = 3'd4;
  localparam logic [2:0] REG_KIND_D      = 3'd5;

  // Frame status codes, in order of precedence after the short check.
  typedef enum logic [2:0] {
    FAIL_NONE    = 3'd0,
    FAIL_SHORT   = 3'd1,
    FAIL_MAGIC   = 3'd2,
    FAIL_VERSION = 3'd3,
    FAIL_KIND    = 3'd4,
    FAIL_LONG    = 3'd5,
    FAIL_SIZE    = 3'd6
  } fail_code_t;

  // Live configuration seen by the frame checker.
  typedef struct packed {
    logic [7:0]  version;
    logic [31:0] max_payload;
    logic [7:0]  kind_a;
    logic [7:0]  kind_b;
    logic [7:0]  kind_c;
    logic [7:0]  kind_d;
  } cfg_t;

  // Gathered header fields.
  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] flags;
    logic [31:0] stream;
    logic [31:0] seq;
    logic [31:0] time_ms;
    logic [31:0] length;
  } header_t;

  // End-of-frame verdict handed to the result register.
  typedef struct packed {
    fail_code_t code;
    header_t    hdr;
  } verdict_t;

  // Magic bytes at header offsets zero to three.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h58;
      2'd1:    val = 8'h56;
      2'd2:    val = 8'h41;
      default: val = 8'h46;
    endcase
    return val;
  endfunction

endpackage

// ===== design/mfhp_frame_state.sv =====
// ============================================================================
// Media frame header parser: per-frame state
// Counts frame bytes, checks the header bytes as they pass, gathers the
// big-endian header fields and forms the verdict on the final byte.
// ============================================================================
module mfhp_frame_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          frame_byte,
  input  logic                end_of_frame,
  input  mfhp_pkg::cfg_t      cfg,
  output mfhp_pkg::verdict_t  verdict
);

  logic [mfhp_pkg::COUNT_W-1:0] byte_count;
  logic [mfhp_pkg::COUNT_W-1:0] byte_count_next;
  mfhp_pkg::fail_code_t         first_fail;
  mfhp_pkg::fail_code_t         first_fail_next;
  mfhp_pkg::fail_code_t         fail_hit;
  mfhp_pkg::fail_code_t         code;
  mfhp_pkg::header_t            hdr;
  mfhp_pkg::header_t            hdr_next;
  logic                         in_header;
  logic [4:0]                   ofs;
  logic                         kind_ok;
  logic [mfhp_pkg::COUNT_W-1:0] size_target;

  assign in_header = byte_count < mfhp_pkg::COUNT_W'(mfhp_pkg::HEADER_BYTES);
  assign ofs       = byte_count[4:0];
  assign kind_ok   = (frame_byte == cfg.kind_a) || (frame_byte == cfg.kind_b) ||
                     (frame_byte == cfg.kind_c) || (frame_byte == cfg.kind_d);

  // Header byte checks and field gathering for the current offset.
  always_comb begin
    hdr_next = hdr;
    fail_hit = mfhp_pkg::FAIL_NONE;
    if (in_header) begin
      if (ofs < mfhp_pkg::OFS_VERSION) begin
        if (frame_byte != mfhp_pkg::magic_byte(ofs[1:0])) begin
          fail_hit = mfhp_pkg::FAIL_MAGIC;
        end
      end else if (ofs == mfhp_pkg::OFS_VERSION) begin
        if (frame_byte != cfg.version) begin
          fail_hit = mfhp_pkg::FAIL_VERSION;
        end
      end else if (ofs == mfhp_pkg::OFS_KIND) begin
        hdr_next.kind = frame_byte;
        if (!kind_ok) begin
          fail_hit = mfhp_pkg::FAIL_KIND;
        end
      end else if (ofs < mfhp_pkg::OFS_STREAM) begin
        hdr_next.flags = {hdr.flags[7:0], frame_byte};
      end else if (ofs < mfhp_pkg::OFS_SEQ) begin
        hdr_next.stream = {hdr.stream[23:0], frame_byte};
      end else if (ofs < mfhp_pkg::OFS_TIME) begin
        hdr_next.seq = {hdr.seq[23:0], frame_byte};
      end else if (ofs < mfhp_pkg::OFS_LENGTH) begin
        hdr_next.time_ms = {hdr.time_ms[23:0], frame_byte};
      end else begin
        hdr_next.length = {hdr.length[23:0], frame_byte};
      end
    end
  end

  // The first failure in byte order sticks for the rest of the frame.
  assign first_fail_next = (first_fail != mfhp_pkg::FAIL_NONE) ? first_fail : fail_hit;

  // Saturating byte counter.
  assign byte_count_next = (byte_count == mfhp_pkg::COUNT_MAX) ? byte_count
                           : byte_count + mfhp_pkg::COUNT_W'(1);

  assign size_target = mfhp_pkg::COUNT_W'(mfhp_pkg::HEADER_BYTES)
                       + {1'b0, hdr_next.length};

  // Verdict for a frame that ends with this byte.
  always_comb begin
    if (byte_count_next < mfhp_pkg::COUNT_W'(mfhp_pkg::HEADER_BYTES)) begin
      code = mfhp_pkg::FAIL_SHORT;
    end else if (first_fail_next != mfhp_pkg::FAIL_NONE) begin
      code = first_fail_next;
    end else if (hdr_next.length > cfg.max_payload) begin
      code = mfhp_pkg::FAIL_LONG;
    end else if (byte_count_next != size_target) begin
      code = mfhp_pkg::FAIL_SIZE;
    end else begin
      code = mfhp_pkg::FAIL_NONE;
    end
  end

  // A failed frame reports all header fields as zero.
  always_comb begin
    verdict.code = code;
    verdict.hdr  = (code == mfhp_pkg::FAIL_NONE) ? hdr_next : '0;
  end

  // Frame state; the final byte starts the next frame from scratch.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      first_fail <= mfhp_pkg::FAIL_NONE;
      hdr        <= '0;
    end else if (step) begin
      if (end_of_frame) begin
        byte_count <= '0;
        first_fail <= mfhp_pkg::FAIL_NONE;
        hdr        <= '0;
      end else begin
        byte_count <= byte_count_next;
        first_fail <= first_fail_next;
        hdr        <= hdr_next;
      end
    end
  end

endmodule

// ===== design/media_frame_header_parser.sv =====
// ============================================================================
// Media frame header parser
// Checks the 24-byte header of a byte-stream frame and reports one result
// per frame with the status code and the gathered header fields.
// ============================================================================
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_ready  frame_byte, end_of_frame
//   out       source     out_valid/out_ready  frame_ok, fail_code, header fields
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// One byte is taken per cycle. A byte waits in the input register and is
// then folded into the frame state by a single pass of logic, so the result
// of a frame enters the output register as its final byte leaves the input
// register. Bytes keep flowing while a result waits; only the next final
// byte stalls the input until the waiting result is taken. Reset clears the
// frame state and both valid flags and returns the registers to their defaults.
//
module media_frame_header_parser (
  input  logic        clk,
  input  logic        rst,
  // Input requests.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        end_of_frame,
  // Result requests.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ok,
  output logic [2:0]  fail_code,
  output logic [7:0]  kind,
  output logic [15:0] flag_bits,
  output logic [31:0] stream_number,
  output logic [31:0] sequence_number,
  output logic [31:0] time_ms,
  output logic [31:0] body_length,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mfhp_pkg::cfg_t     cfg;
  mfhp_pkg::verdict_t verdict;
  mfhp_pkg::verdict_t out_verdict;
  logic               in_q_valid;
  logic [7:0]         in_q_byte;
  logic               in_q_eof;
  logic               out_free;
  logic               advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.version     <= 8'd1;
      cfg.max_payload <= 32'd65535;
      cfg.kind_a      <= 8'd0;
      cfg.kind_b      <= 8'd1;
      cfg.kind_c      <= 8'd2;
      cfg.kind_d      <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfhp_pkg::REG_VERSION:     cfg.version     <= cfg_data[7:0];
        mfhp_pkg::REG_MAX_PAYLOAD: cfg.max_payload <= cfg_data;
        mfhp_pkg::REG_KIND_A:      cfg.kind_a      <= cfg_data[7:0];
        mfhp_pkg::REG_KIND_B:      cfg.kind_b      <= cfg_data[7:0];
        mfhp_pkg::REG_KIND_C:      cfg.kind_c      <= cfg_data[7:0];
        mfhp_pkg::REG_KIND_D:      cfg.kind_d      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Flow control: a final byte needs a free output register to retire.
  assign out_free = !out_valid || out_ready;
  assign advance  = in_q_valid && (!in_q_eof || out_free);
  assign in_ready = !in_q_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= frame_byte;
      in_q_eof  <= end_of_frame;
    end
  end

  mfhp_frame_state u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .frame_byte   (in_q_byte),
    .end_of_frame (in_q_eof),
    .cfg          (cfg),
    .verdict      (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_q_eof) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_eof) begin
      out_verdict <= verdict;
    end
  end

  assign frame_ok        = (out_verdict.code == mfhp_pkg::FAIL_NONE);
  assign fail_code       = 3'(out_verdict.code);
  assign kind            = out_verdict.hdr.kind;
  assign flag_bits       = out_verdict.hdr.flags;
  assign stream_number   = out_verdict.hdr.stream;
  assign sequence_number = out_verdict.hdr.seq;
  assign time_ms         = out_verdict.hdr.time_ms;
  assign body_length     = out_verdict.hdr.length;

endmodule

// ===== design/mfhp_checker.sv =====
// ============================================================================
// Media frame header parser port checker
// Watches the top-level ports and flags results that break the output rules.
// ============================================================================
module mfhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_ok,
  input logic [2:0]  fail_code,
  input logic [7:0]  kind,
  input logic [15:0] flag_bits,
  input logic [31:0] stream_number,
  input logic [31:0] sequence_number,
  input logic [31:0] time_ms,
  input logic [31:0] body_length
);

  // A stalled result keeps its status.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fail_code) && $stable(frame_ok))
    else $error("result changed while stalled");

  // The ok flag agrees with the status code.
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_ok == (fail_code == 3'(mfhp_pkg::FAIL_NONE))))
    else $error("frame_ok disagrees with fail_code");

  // A failed frame reports zero header fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> kind == 8'd0 && flag_bits == 16'd0 &&
      stream_number == 32'd0 && sequence_number == 32'd0 &&
      time_ms == 32'd0 && body_length == 32'd0)
    else $error("failed frame carries header fields");

  // No result is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind media_frame_header_parser mfhp_checker u_mfhp_checker (.*);

// ===== test/media_frame_header_parser_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Media frame header parser testbench
// Sends whole frames one byte per request through the input channel and
// compares each result request with a cycle-free prediction of the parser.
// It covers good frames, each kind of broken header, short frames, length
// errors and noise, over several register settings and idle patterns.
// ============================================================================
module media_frame_header_parser_tb;

  localparam int          STALL_LIMIT  = 5000;
  localparam int          SETTLE_TICKS = 8;
  localparam int          PHASE_BYTES  = 270;
  localparam logic [31:0] MAGIC_WORD   = 32'h5856_4146;
  localparam logic [2:0]  REG_SPARE0   = 3'd6;
  localparam logic [2:0]  REG_SPARE1   = 3'd7;

  // One byte request as the driver presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // One frame verdict as the parser reports it.
  typedef struct packed {
    logic                 ok;
    mfhp_pkg::fail_code_t code;
    mfhp_pkg::header_t    hdr;
  } frame_verdict_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte   = '0;
  logic        end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        frame_ok;
  logic [2:0]  fail_code;
  logic [7:0]  kind;
  logic [15:0] flag_bits;
  logic [31:0] stream_number;
  logic [31:0] sequence_number;
  logic [31:0] time_ms;
  logic [31:0] body_length;
  logic        cfg_we       = 1'b0;
  logic [2:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  // Stimulus queues and the results still owed by the parser.
  byte_req_t      pending_bytes[$];
  logic [7:0]     frame_buf[$];
  frame_verdict_t awaited_verdicts[$];
  byte_req_t      next_req;

  // Register copy and the frame state of the prediction.
  mfhp_pkg::cfg_t                 regs;
  logic [mfhp_pkg::COUNT_W-1:0]   seen_count = '0;
  mfhp_pkg::fail_code_t           first_bad  = mfhp_pkg::FAIL_NONE;
  mfhp_pkg::header_t              hdr_acc    = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_queued  = 0;
  int bytes_taken   = 0;
  int frames_queued = 0;
  int results_seen  = 0;
  int settings_used = 1;
  int error_count   = 0;
  int stall_cycles  = 0;
  int code_hits[7];

  media_frame_header_parser i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .frame_byte      (frame_byte),
    .end_of_frame    (end_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_ok        (frame_ok),
    .fail_code       (fail_code),
    .kind            (kind),
    .flag_bits       (flag_bits),
    .stream_number   (stream_number),
    .sequence_number (sequence_number),
    .time_ms         (time_ms),
    .body_length     (body_length),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic kind_listed(input logic [7:0] k);
    return k == regs.kind_a || k == regs.kind_b || k == regs.kind_c || k == regs.kind_d;
  endfunction

  task automatic note_first_fail(input mfhp_pkg::fail_code_t code);
    if (first_bad == mfhp_pkg::FAIL_NONE) first_bad = code;
  endtask

  // Folds one accepted byte into the frame state; a final byte closes the
  // frame and queues its verdict.
  task automatic fold_byte(input logic [7:0] b, input logic last);
    mfhp_pkg::fail_code_t code;
    frame_verdict_t       v;
    int                   idx;
    idx = int'(seen_count[1:0]);
    if (seen_count < 4) begin
      if (b != MAGIC_WORD[8*(3-idx) +: 8]) note_first_fail(mfhp_pkg::FAIL_MAGIC);
    end else if (seen_count == mfhp_pkg::OFS_VERSION) begin
      if (b != regs.version) note_first_fail(mfhp_pkg::FAIL_VERSION);
    end else if (seen_count == mfhp_pkg::OFS_KIND) begin
      hdr_acc.kind = b;
      if (!kind_listed(b)) note_first_fail(mfhp_pkg::FAIL_KIND);
    end else if (seen_count < mfhp_pkg::OFS_STREAM) begin
      hdr_acc.flags = {hdr_acc.flags[7:0], b};
    end else if (seen_count < mfhp_pkg::OFS_SEQ) begin
      hdr_acc.stream = {hdr_acc.stream[23:0], b};
    end else if (seen_count < mfhp_pkg::OFS_TIME) begin
      hdr_acc.seq = {hdr_acc.seq[23:0], b};
    end else if (seen_count < mfhp_pkg::OFS_LENGTH) begin
      hdr_acc.time_ms = {hdr_acc.time_ms[23:0], b};
    end else if (seen_count < mfhp_pkg::HEADER_BYTES) begin
      hdr_acc.length = {hdr_acc.length[23:0], b};
    end

    // The byte counter sticks at its top value.
    if (seen_count != mfhp_pkg::COUNT_MAX) seen_count = seen_count + 1'b1;

    if (last) begin
      if (seen_count < mfhp_pkg::HEADER_BYTES) code = mfhp_pkg::FAIL_SHORT;
      else if (first_bad != mfhp_pkg::FAIL_NONE) code = first_bad;
      else if (hdr_acc.length > regs.max_payload) code = mfhp_pkg::FAIL_LONG;
      else if (seen_count != {1'b0, hdr_acc.length}
                             + mfhp_pkg::COUNT_W'(mfhp_pkg::HEADER_BYTES))
        code = mfhp_pkg::FAIL_SIZE;
      else code = mfhp_pkg::FAIL_NONE;
      v.ok   = (code == mfhp_pkg::FAIL_NONE);
      v.code = code;
      v.hdr  = v.ok ? hdr_acc : '0;
      awaited_verdicts.push_back(v);
      seen_count = '0;
      first_bad  = mfhp_pkg::FAIL_NONE;
      hdr_acc    = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic string show_verdict(input frame_verdict_t v);
    return $sformatf("ok=%0b code=%0d kind=%h flags=%h stream=%h seq=%h time=%h len=%h",
                     v.ok, v.code, v.hdr.kind, v.hdr.flags, v.hdr.stream, v.hdr.seq,
                     v.hdr.time_ms, v.hdr.length);
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    frame_verdict_t want;
    frame_verdict_t got;
    string          bad;
    got.ok          = frame_ok;
    got.code        = mfhp_pkg::fail_code_t'(fail_code);
    got.hdr.kind    = kind;
    got.hdr.flags   = flag_bits;
    got.hdr.stream  = stream_number;
    got.hdr.seq     = sequence_number;
    got.hdr.time_ms = time_ms;
    got.hdr.length  = body_length;
    results_seen++;
    if (awaited_verdicts.size() == 0) begin
      note_error({"result with no frame outstanding: ", show_verdict(got)});
    end else begin
      want = awaited_verdicts.pop_front();
      code_hits[want.code]++;
      bad = "";
      if (got.ok !== want.ok) bad = {bad, " frame_ok"};
      if (got.code !== want.code) bad = {bad, " fail_code"};
      if (got.hdr.kind !== want.hdr.kind) bad = {bad, " kind"};
      if (got.hdr.flags !== want.hdr.flags) bad = {bad, " flag_bits"};
      if (got.hdr.stream !== want.hdr.stream) bad = {bad, " stream_number"};
      if (got.hdr.seq !== want.hdr.seq) bad = {bad, " sequence_number"};
      if (got.hdr.time_ms !== want.hdr.time_ms) bad = {bad, " time_ms"};
      if (got.hdr.length !== want.hdr.length) bad = {bad, " body_length"};
      if (bad != "")
        note_error($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                             results_seen, bad, show_verdict(want), show_verdict(got)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver, monitor and watchdog
  // ---------------------------------------------------------------------------

  // Presents queued bytes, idling at random while a slot is free.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fold_byte(frame_byte, end_of_frame);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_bytes.pop_front();
          in_valid     <= 1'b1;
          frame_byte   <= next_req.data;
          end_of_frame <= next_req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Takes result requests, stalling at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run when no request moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("media_frame_header_parser_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Writes one register and mirrors it in the prediction; spare indexes are
  // dropped by the parser.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mfhp_pkg::REG_VERSION:     regs.version     = val[7:0];
      mfhp_pkg::REG_MAX_PAYLOAD: regs.max_payload = val;
      mfhp_pkg::REG_KIND_A:      regs.kind_a      = val[7:0];
      mfhp_pkg::REG_KIND_B:      regs.kind_b      = val[7:0];
      mfhp_pkg::REG_KIND_C:      regs.kind_c      = val[7:0];
      mfhp_pkg::REG_KIND_D:      regs.kind_d      = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_random_kinds();
    write_reg(mfhp_pkg::REG_KIND_A, $urandom);
    write_reg(mfhp_pkg::REG_KIND_B, $urandom);
    write_reg(mfhp_pkg::REG_KIND_C, $urandom);
    write_reg(mfhp_pkg::REG_KIND_D, $urandom);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic add_header(input logic [31:0] mg, input logic [7:0] ver,
                            input logic [7:0] kd, input logic [15:0] fl,
                            input logic [31:0] st, input logic [31:0] sq,
                            input logic [31:0] tm, input logic [31:0] ln);
    push_word(mg);
    frame_buf.push_back(ver);
    frame_buf.push_back(kd);
    frame_buf.push_back(fl[15:8]);
    frame_buf.push_back(fl[7:0]);
    push_word(st);
    push_word(sq);
    push_word(tm);
    push_word(ln);
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endtask

  // Moves the assembled frame to the driver, marking its final byte.
  task automatic flush_frame();
    byte_req_t r;
    foreach (frame_buf[i]) begin
      r.data = frame_buf[i];
      r.last = (i == frame_buf.size() - 1);
      pending_bytes.push_back(r);
    end
    bytes_queued += frame_buf.size();
    frames_queued++;
    frame_buf.delete();
  endtask

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(3))
      0:       return regs.kind_a;
      1:       return regs.kind_b;
      2:       return regs.kind_c;
      default: return regs.kind_d;
    endcase
  endfunction

  // Payload lengths stay small so that frames stay short.
  function automatic logic [31:0] pick_length();
    if (regs.max_payload < 12) return $urandom_range(regs.max_payload);
    if (regs.max_payload >= 40 && $urandom_range(9) == 0) return $urandom_range(40, 13);
    return $urandom_range(12);
  endfunction

  // Builds one random frame: mostly well formed, the rest broken on purpose.
  task automatic queue_random_frame();
    int          sel;
    int          send;
    int          cut;
    logic [31:0] mg;
    logic [7:0]  ver;
    logic [7:0]  kd;
    logic [31:0] len;
    sel  = $urandom_range(99);
    mg   = MAGIC_WORD;
    ver  = regs.version;
    kd   = pick_kind();
    len  = pick_length();
    send = int'(len);
    if (sel < 55) begin
      // Well formed.
    end else if (sel < 61) begin
      mg = mg ^ (32'h1 << $urandom_range(31));
    end else if (sel < 67) begin
      ver = ver ^ 8'($urandom_range(255, 1));
    end else if (sel < 73) begin
      do kd = 8'($urandom); while (kind_listed(kd));
    end else if (sel < 80 && regs.max_payload != '1) begin
      len  = (regs.max_payload > 32'hFFFF_FFF0) ? '1 : regs.max_payload + 1 + $urandom_range(8);
      send = $urandom_range(4);
    end else if (sel < 88) begin
      if (regs.max_payload == '1 && $urandom_range(3) == 0) begin
        len  = '1;
        send = $urandom_range(4);
      end else if (len != 0 && $urandom_range(1) == 1) begin
        send = $urandom_range(int'(len) - 1);
      end else begin
        send = int'(len) + 1 + $urandom_range(2);
      end
    end
    add_header(mg, ver, kd, 16'($urandom), $urandom, $urandom, $urandom, len);
    if (sel >= 94) begin
      // Noise of random length.
      frame_buf.delete();
      add_random($urandom_range(40, 1));
    end else if (sel >= 88) begin
      // Header cut short.
      cut = $urandom_range(23, 1);
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end else begin
      add_random(send);
    end
    flush_frame();
  endtask

  // Waits until every byte is taken and every result has come back, then
  // lets the parser settle.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || awaited_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int start_bytes;
    regs = '{version: 8'd1, max_payload: 32'd65535,
             kind_a: 8'd0, kind_b: 8'd1, kind_c: 8'd2, kind_d: 8'd3};
    foreach (code_hits[i]) code_hits[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 77;

    // Directed frames under the reset register values.
    // Smallest good frame with every field zero.
    add_header(MAGIC_WORD, 8'd1, 8'd0, 16'h0, '0, '0, '0, '0);
    flush_frame();
    // Good frame with flags, stream, sequence and time at their top values.
    add_header(MAGIC_WORD, 8'd1, 8'd3, 16'hFFFF, '1, '1, '1, 32'd2);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    flush_frame();
    // A frame of a single byte.
    frame_buf.push_back(8'h58);
    flush_frame();
    // Header one byte short.
    add_header(MAGIC_WORD, 8'd1, 8'd1, 16'h1234, 32'd1, 32'd2, 32'd3, '0);
    void'(frame_buf.pop_back());
    flush_frame();
    // Bad magic ahead of a bad version and kind: magic is reported.
    add_header(MAGIC_WORD ^ 32'h1, 8'd2, 8'd9, 16'h0, '0, '0, '0, '0);
    flush_frame();
    // Bad version ahead of a bad kind.
    add_header(MAGIC_WORD, 8'd0, 8'd255, 16'h0, '0, '0, '0, '0);
    flush_frame();
    // Kind just past the listed codes.
    add_header(MAGIC_WORD, 8'd1, 8'd4, 16'h0, '0, '0, '0, '0);
    flush_frame();
    // Length one over the limit with no payload: too long wins over size.
    add_header(MAGIC_WORD, 8'd1, 8'd2, 16'h8001, '0, '0, '0, 32'd65536);
    flush_frame();
    // Length at the limit with one payload byte.
    add_header(MAGIC_WORD, 8'd1, 8'd2, 16'h0, '0, '0, '0, 32'd65535);
    add_random(1);
    flush_frame();
    // Three payload bytes announced, four sent.
    add_header(MAGIC_WORD, 8'd1, 8'd1, 16'h0, '0, '0, '0, 32'd3);
    add_random(4);
    flush_frame();
    // Largest length field.
    add_header(MAGIC_WORD, 8'd1, 8'd0, 16'h0, '0, '0, '0, '1);
    flush_frame();
    wait_drained();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0:       begin send_idle_pct = 26; recv_idle_pct = 77; end
        1:       begin send_idle_pct = 77; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (p)
        0: begin
          write_reg(mfhp_pkg::REG_VERSION, $urandom);
          write_reg(mfhp_pkg::REG_MAX_PAYLOAD, $urandom_range(20));
          write_random_kinds();
        end
        1: begin
          // Lowest values but one kind code of 255, with duplicate kind codes and spare indexes.
          write_reg(mfhp_pkg::REG_VERSION, 32'd0);
          write_reg(mfhp_pkg::REG_MAX_PAYLOAD, 32'd0);
          write_reg(mfhp_pkg::REG_KIND_A, 32'd0);
          write_reg(mfhp_pkg::REG_KIND_B, 32'd0);
          write_reg(mfhp_pkg::REG_KIND_C, 32'd255);
          write_reg(mfhp_pkg::REG_KIND_D, 32'd0);
          write_reg(REG_SPARE0, $urandom);
          write_reg(REG_SPARE1, $urandom);
        end
        2: begin
          // Highest version, payload limit and first kind code.
          write_reg(mfhp_pkg::REG_VERSION, 32'd255);
          write_reg(mfhp_pkg::REG_MAX_PAYLOAD, '1);
          write_reg(mfhp_pkg::REG_KIND_A, 32'd255);
          write_reg(mfhp_pkg::REG_KIND_B, 32'd128);
          write_reg(mfhp_pkg::REG_KIND_C, 32'd127);
          write_reg(mfhp_pkg::REG_KIND_D, 32'd1);
          write_reg(REG_SPARE1, '1);
        end
        3: begin
          write_reg(mfhp_pkg::REG_VERSION, $urandom);
          write_reg(mfhp_pkg::REG_MAX_PAYLOAD, $urandom);
          write_random_kinds();
        end
        4: begin
          write_reg(mfhp_pkg::REG_VERSION, $urandom);
          write_reg(mfhp_pkg::REG_MAX_PAYLOAD, 32'd12);
          write_random_kinds();
        end
        default: begin
          write_reg(mfhp_pkg::REG_VERSION, $urandom);
          write_reg(mfhp_pkg::REG_MAX_PAYLOAD, $urandom_range(40));
          write_random_kinds();
        end
      endcase
      settings_used++;
      start_bytes = bytes_queued;
      while (bytes_queued - start_bytes < PHASE_BYTES) queue_random_frame();
      wait_drained();
    end

    $display("Sent %0d bytes in %0d frames under %0d register settings; %0d results checked.",
             bytes_taken, frames_queued, settings_used, results_seen);
    $display("Results by status: ok %0d, short %0d, magic %0d, version %0d, kind %0d,",
             code_hits[mfhp_pkg::FAIL_NONE], code_hits[mfhp_pkg::FAIL_SHORT],
             code_hits[mfhp_pkg::FAIL_MAGIC], code_hits[mfhp_pkg::FAIL_VERSION],
             code_hits[mfhp_pkg::FAIL_KIND]);
    $display("  long %0d, size %0d; %0d errors.",
             code_hits[mfhp_pkg::FAIL_LONG], code_hits[mfhp_pkg::FAIL_SIZE], error_count);
    if (error_count == 0) begin
      $display("media_frame_header_parser_tb: PASS");
    end else begin
      $display("media_frame_header_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
